// ===== design/hmbd_pkg.sv =====
// Shared types and constants for the handheld memory bus decoder.
`default_nettype none
package hmbd_pkg;
	localparam int VideoRamBytes = 8192;
	localparam int WorkRamBytes = 8192;
	localparam int SpriteTableBytes = 160;

	typedef enum logic [1:0] {
		MODE_READ = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_IO = 2'd2,
		MODE_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_CART = 2'd1,
		ST_UNUSABLE = 2'd2,
		ST_DMA_BAD = 2'd3
	} status_t;

	localparam logic [6:0] IO_JOYPAD = 7'h00;
	localparam logic [6:0] IO_DIVIDER = 7'h04;
	localparam logic [6:0] IO_LINE = 7'h44;
	localparam logic [6:0] IO_DMA = 7'h46;

	// One decoded access, handed from the front end to the back end.
	typedef struct packed {
		logic [1:0] mode;
		logic [15:0] address;
		logic [7:0] write_data;
		logic [7:0] joypad_state;
	} access_t;

	// True for addresses forwarded to the cartridge.
	function automatic logic is_cart(input logic [15:0] a);
		return (a < 16'h8000) || (a >= 16'ha000 && a < 16'hc000);
	endfunction
endpackage
`default_nettype wire

// ===== design/hmbd_front.sv =====
// Front end: accepts access beats into a two-entry queue.
`default_nettype none
module hmbd_front
	import hmbd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire access_t in_item,
	output logic q_valid,
	input wire logic q_ready,
	output access_t q_item
);
	access_t slot_q [2];
	logic [1:0] count_q;
	logic rd_ptr_q, wr_ptr_q;
	logic push, pop;

	assign in_ready = count_q != 2'd2;
	assign q_valid = count_q != 2'd0;
	assign q_item = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	// Hold queued beats.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_item;
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== design/hmbd_back.sv =====
// Back end: serves accesses against the local stores and runs sprite DMA.
`default_nettype none
module hmbd_back
	import hmbd_pkg::*;
#(
	parameter int VIDEO_RAM_BYTES = VideoRamBytes,
	parameter int WORK_RAM_BYTES = WorkRamBytes,
	parameter int SPRITE_TABLE_BYTES = SpriteTableBytes
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire access_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_read_data,
	output logic [1:0] out_status
);
	localparam int VAW = $clog2(VIDEO_RAM_BYTES);
	localparam int WAW = $clog2(WORK_RAM_BYTES);
	localparam int SAW = $clog2(SPRITE_TABLE_BYTES);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_DMA, S_OUT} state_t;

	logic [7:0] video_ram [VIDEO_RAM_BYTES];
	logic [7:0] work_ram [WORK_RAM_BYTES];
	logic [7:0] sprite_table [SPRITE_TABLE_BYTES];
	logic [7:0] high_ram [127];
	logic [7:0] io_q [128];
	logic [7:0] ie_q;

	state_t state_q;
	access_t cur_q;
	logic [7:0] vram_rd_q, wram_rd_q, spr_rd_q, hram_rd_q, io_rd_q;
	logic [2:0] src_sel_q;
	logic [7:0] dma_cnt_q;
	logic dma_wr_q;
	logic [SAW-1:0] dma_dst_q;
	logic [7:0] rd_q;
	logic [1:0] st_q;

	// Address whose data the memories present next cycle.
	logic [15:0] raddr;
	logic [15:0] dma_addr;
	logic [2:0] sel;
	logic [7:0] sel_data;
	logic [15:0] wa;
	logic [6:0] io_idx;
	logic [7:0] wv;

	assign dma_addr = {cur_q.write_data, dma_cnt_q};
	assign raddr = (state_q == S_DMA) ? dma_addr : q_item.address;
	assign q_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_read_data = rd_q;
	assign out_status = st_q;
	assign wa = cur_q.address;
	assign io_idx = wa[6:0];

	// Region codes: 0 vram, 1 wram, 2 sprite, 3 io, 4 hram, 5 ie, 6 none.
	always_comb begin
		if (is_cart(raddr)) sel = 3'd6;
		else if (raddr < 16'ha000) sel = 3'd0;
		else if (raddr < 16'hfe00) sel = 3'd1;
		else if (raddr < 16'hfea0) sel = 3'd2;
		else if (raddr < 16'hff00) sel = 3'd6;
		else if (raddr < 16'hff80) sel = 3'd3;
		else if (raddr < 16'hffff) sel = 3'd4;
		else sel = 3'd5;
	end

	always_comb begin
		case (src_sel_q)
			3'd0: sel_data = vram_rd_q;
			3'd1: sel_data = wram_rd_q;
			3'd2: sel_data = spr_rd_q;
			3'd3: sel_data = io_rd_q;
			3'd4: sel_data = hram_rd_q;
			3'd5: sel_data = ie_q;
			default: sel_data = 8'd0;
		endcase
	end

	// Registered memory reads.
	logic [15:0] wram_off, spr_off, hram_off;
	assign wram_off = (raddr < 16'he000) ? raddr - 16'hc000 : raddr - 16'he000;
	assign spr_off = raddr - 16'hfe00;
	assign hram_off = raddr - 16'hff80;
	always_ff @(posedge clk) begin
		vram_rd_q <= video_ram[raddr[VAW-1:0]];
		wram_rd_q <= work_ram[wram_off[WAW-1:0]];
		spr_rd_q <= sprite_table[spr_off[SAW-1:0]];
		hram_rd_q <= high_ram[hram_off[6:0]];
		src_sel_q <= sel;
	end

	// Bus write value after side effects of the IO register block.
	always_comb begin
		wv = cur_q.write_data;
		if (cur_q.mode == MODE_WRITE && wa[15:7] == 9'h1fe) begin
			if (io_idx == IO_DIVIDER || io_idx == IO_LINE) wv = 8'd0;
			else if (io_idx == IO_JOYPAD) wv = cur_q.joypad_state;
		end
	end

	// Memory writes: sprite DMA or the current access.
	logic do_wr;
	assign do_wr = state_q == S_READ && (cur_q.mode == MODE_WRITE || cur_q.mode == MODE_IO);
	logic [15:0] w_wram, w_spr, w_hram;
	assign w_wram = (wa < 16'he000) ? wa - 16'hc000 : wa - 16'he000;
	assign w_spr = wa - 16'hfe00;
	assign w_hram = wa - 16'hff80;
	always_ff @(posedge clk) begin
		if (dma_wr_q) sprite_table[dma_dst_q] <= sel_data;
		if (do_wr && cur_q.mode == MODE_WRITE && !is_cart(wa)) begin
			if (wa < 16'ha000) video_ram[wa[VAW-1:0]] <= wv;
			else if (wa < 16'hfe00) work_ram[w_wram[WAW-1:0]] <= wv;
			else if (wa < 16'hfea0) sprite_table[w_spr[SAW-1:0]] <= wv;
			else if (wa >= 16'hff80 && wa < 16'hffff) high_ram[w_hram[6:0]] <= wv;
		end
	end

	// Control, IO registers and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dma_cnt_q <= 8'd0;
			dma_wr_q <= 1'b0;
			ie_q <= 8'd0;
			for (int i = 0; i < 128; i++) io_q[i] <= 8'd0;
		end else begin
			dma_wr_q <= 1'b0;
			io_rd_q <= io_q[raddr[6:0]];
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					rd_q <= 8'd0;
					st_q <= ST_DONE;
					if (cur_q.mode == MODE_IO) begin
						if (wa >= 16'hff00 && wa < 16'hff80) io_q[io_idx] <= cur_q.write_data;
						else st_q <= ST_UNUSABLE;
						state_q <= S_OUT;
					end else if (cur_q.mode == MODE_WRITE) begin
						state_q <= S_OUT;
						if (is_cart(wa)) st_q <= ST_CART;
						else if (wa >= 16'hfea0 && wa < 16'hff00) st_q <= ST_UNUSABLE;
						else if (wa == 16'hffff) ie_q <= wv;
						else if (wa >= 16'hff00 && wa < 16'hff80) begin
							if (io_idx == IO_DMA) begin
								if (is_cart({cur_q.write_data, 8'h00})) begin
									st_q <= ST_DMA_BAD;
									io_q[io_idx] <= wv;
								end else begin
									dma_cnt_q <= 8'd0;
									state_q <= S_DMA;
								end
							end else io_q[io_idx] <= wv;
						end
					end else begin
						rd_q <= sel_data;
						if (src_sel_q == 3'd6)
							st_q <= (wa >= 16'hfea0 && wa < 16'hff00) ? ST_UNUSABLE : ST_CART;
						state_q <= S_OUT;
					end
				end
				S_DMA: begin
					// Issue one read per cycle; the write lands in the next cycle.
					if (dma_cnt_q != 8'(SPRITE_TABLE_BYTES)) begin
						dma_wr_q <= 1'b1;
						dma_dst_q <= dma_cnt_q[SAW-1:0];
						dma_cnt_q <= dma_cnt_q + 8'd1;
					end else if (!dma_wr_q) begin
						io_q[IO_DMA] <= cur_q.write_data;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/handheld_memory_bus_decoder_unit.sv =====
// Ordinary accesses pass through the idle, read and output states of the back end.
// The back end takes a new access only after the last result is taken; a DMA register
// write copies the sprite table, one sprite byte per cycle through the shared read port.
// A two-beat input queue accepts beats while the back end is busy.
// Reset (arst_n low) clears control, IO registers and interrupt enable.
`default_nettype none
module handheld_memory_bus_decoder_unit
	import hmbd_pkg::*;
#(
	parameter int VIDEO_RAM_BYTES = VideoRamBytes,
	parameter int WORK_RAM_BYTES = WorkRamBytes,
	parameter int SPRITE_TABLE_BYTES = SpriteTableBytes
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// mode[1:0], address[17:2], write_data[25:18], joypad_state[33:26], zero pad
	input wire logic [39:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// read_data[7:0], status[9:8], zero pad
	output logic [15:0] m_tdata
);
	access_t in_item, q_item;
	logic q_valid, q_ready;
	logic [7:0] rd;
	logic [1:0] st;

	assign in_item = '{mode: s_tdata[1:0], address: s_tdata[17:2],
		write_data: s_tdata[25:18], joypad_state: s_tdata[33:26]};
	assign m_tdata = {6'd0, st, rd};

	hmbd_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	hmbd_back #(
		.VIDEO_RAM_BYTES(VIDEO_RAM_BYTES), .WORK_RAM_BYTES(WORK_RAM_BYTES),
		.SPRITE_TABLE_BYTES(SPRITE_TABLE_BYTES)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_read_data(rd), .out_status(st)
	);
endmodule
`default_nettype wire

// ===== design/hmbd_checker.sv =====
// Port-level checker for the memory bus decoder, bound to the top level.
`default_nettype none
module hmbd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [39:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [15:0] m_tdata
);
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:10] == 6'd0) else $error("pad bits set");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_cart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9:8] != 2'd0 |-> m_tdata[7:0] == 8'd0)
		else $error("data on error");
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid) else $error("valid in reset");
endmodule

bind handheld_memory_bus_decoder_unit hmbd_checker u_chk (.*);
`default_nettype wire
